/* hdl/rsec_pkg.sv */
// ----------------------------------------------------------------------------
// rsec_pkg
// Shared constants for the ray / sphere far-exit clip pipeline.
// ----------------------------------------------------------------------------
package rsec_pkg;

    // direction components are always 16-bit signed, fraction bits vary
    localparam int DIR_W = 16;

endpackage

/* hdl/ray_sphere_exit_clip_top.sv */
// ----------------------------------------------------------------------------
// ray_sphere_exit_clip_top
// Ray / sphere far-exit clip: one ray in, one hit flag and exit point out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one ray per transaction: origin, unit direction
//   (Q1.14 by default) and sphere center. Master stream returns one result
//   per ray, in order: tuser is the hit flag, tdata the far exit point
//   (zero when there is no hit, each axis saturated otherwise).
//   The radius is written through the cfg channel (always ready) while no
//   ray is in flight; it resets to 0.
//   The pipeline has 7 front stages for the projection and radicand,
//   COORD_BITS + 4 stages of the bit-per-stage square root, and 4 back
//   stages ending in the output register. Every unit is fully pipelined,
//   so one ray is taken per cycle while the receiver keeps up.
//   When the receiver stalls, the output register holds. Each of the three
//   units advances as a whole and freezes once its last stage holds a ray
//   that the next unit cannot take; tready on the slave side follows the
//   front unit, so bubbles inside a unit are not squeezed out. Reset clears
//   all valid bits and the radius; payload registers are not reset.
// ----------------------------------------------------------------------------
module ray_sphere_exit_clip_top #(
    parameter int COORD_BITS    = 24,
    parameter int DIR_FRAC_BITS = 14
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // center_x, center_y, center_z, zero fill
    input  logic [((6*COORD_BITS+3*rsec_pkg::DIR_W+7)/8)*8-1:0] i_s_axis_tdata,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // exit_x, exit_y, exit_z, zero fill
    output logic [((3*COORD_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // hit
    output logic                    o_m_axis_tuser,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    input  logic [COORD_BITS-2:0]   i_cfg_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready
);
    import rsec_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int OUT_TW = ((3 * C + 7) / 8) * 8;
    localparam int RAD_W  = 2 * C + 7;
    localparam int Q_W    = (RAD_W + 1) / 2;
    localparam int SIDE_W = 4 * C + 3 * DIR_W + 4;

    // radius register
    logic [C-2:0] r_radius;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
        end else if (i_cfg_valid) begin
            r_radius <= i_cfg_data;
        end
    end

    // unpack the ray
    logic signed [C-1:0]     w_org_x, w_org_y, w_org_z;
    logic signed [C-1:0]     w_cen_x, w_cen_y, w_cen_z;
    logic signed [DIR_W-1:0] w_dir_x, w_dir_y, w_dir_z;

    assign w_org_x = $signed(i_s_axis_tdata[0 +: C]);
    assign w_org_y = $signed(i_s_axis_tdata[C +: C]);
    assign w_org_z = $signed(i_s_axis_tdata[2*C +: C]);
    assign w_dir_x = $signed(i_s_axis_tdata[3*C +: DIR_W]);
    assign w_dir_y = $signed(i_s_axis_tdata[3*C+DIR_W +: DIR_W]);
    assign w_dir_z = $signed(i_s_axis_tdata[3*C+2*DIR_W +: DIR_W]);
    assign w_cen_x = $signed(i_s_axis_tdata[3*C+3*DIR_W +: C]);
    assign w_cen_y = $signed(i_s_axis_tdata[4*C+3*DIR_W +: C]);
    assign w_cen_z = $signed(i_s_axis_tdata[5*C+3*DIR_W +: C]);

    logic              w_f_valid, w_s_ready;
    logic [RAD_W-1:0]  w_radicand;
    logic [SIDE_W-1:0] w_f_side;
    logic              w_q_valid, w_e_ready;
    logic [Q_W-1:0]    w_root;
    logic [SIDE_W-1:0] w_q_side;
    logic              w_hit;
    logic signed [C-1:0] w_exit_x, w_exit_y, w_exit_z;

    rsec_proj #(
        .COORD_BITS    (COORD_BITS),
        .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_proj (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_org_x    (w_org_x),
        .i_org_y    (w_org_y),
        .i_org_z    (w_org_z),
        .i_dir_x    (w_dir_x),
        .i_dir_y    (w_dir_y),
        .i_dir_z    (w_dir_z),
        .i_cen_x    (w_cen_x),
        .i_cen_y    (w_cen_y),
        .i_cen_z    (w_cen_z),
        .i_radius   (r_radius),
        .o_valid    (w_f_valid),
        .i_ready    (w_s_ready),
        .o_radicand (w_radicand),
        .o_side     (w_f_side)
    );

    rsec_sqrt #(
        .RAD_W  (RAD_W),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_f_valid),
        .o_ready    (w_s_ready),
        .i_radicand (w_radicand),
        .i_side     (w_f_side),
        .o_valid    (w_q_valid),
        .i_ready    (w_e_ready),
        .o_root     (w_root),
        .o_side     (w_q_side)
    );

    rsec_exit #(
        .COORD_BITS    (COORD_BITS),
        .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_exit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .o_ready  (w_e_ready),
        .i_root   (w_root),
        .i_side   (w_q_side),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_hit    (w_hit),
        .o_exit_x (w_exit_x),
        .o_exit_y (w_exit_y),
        .o_exit_z (w_exit_z)
    );

    assign o_m_axis_tdata = OUT_TW'({w_exit_z, w_exit_y, w_exit_x});
    assign o_m_axis_tuser = w_hit;

    // a miss always carries a zero exit point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("miss result with nonzero exit point");

    // with no result pending every stage can move, so the input must be open
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked while output register is empty");

    // reset empties the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

/* hdl/rsec_proj.sv */
// ----------------------------------------------------------------------------
// rsec_proj
// Front end: center-origin vector, projection onto the direction, rounding
// and clamping of t, and the radicand r^2 + t^2 - |v|^2 with the hit test.
// Seven register stages, all advanced by one enable.
// ----------------------------------------------------------------------------
module rsec_proj #(
    parameter int COORD_BITS    = 24,
    parameter int DIR_FRAC_BITS = 14
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  logic signed [COORD_BITS-1:0]                i_org_x,
    input  logic signed [COORD_BITS-1:0]                i_org_y,
    input  logic signed [COORD_BITS-1:0]                i_org_z,
    input  logic signed [rsec_pkg::DIR_W-1:0]           i_dir_x,
    input  logic signed [rsec_pkg::DIR_W-1:0]           i_dir_y,
    input  logic signed [rsec_pkg::DIR_W-1:0]           i_dir_z,
    input  logic signed [COORD_BITS-1:0]                i_cen_x,
    input  logic signed [COORD_BITS-1:0]                i_cen_y,
    input  logic signed [COORD_BITS-1:0]                i_cen_z,
    input  logic        [COORD_BITS-2:0]                i_radius,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output logic        [2*COORD_BITS+6:0]              o_radicand,
    // side: origin x,y,z, dir x,y,z, t, hit (lowest bit up)
    output logic        [4*COORD_BITS+3*rsec_pkg::DIR_W+3:0] o_side
);
    import rsec_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int V_W    = C + 1;
    localparam int DP_W   = V_W + DIR_W;
    localparam int DOT_W  = DP_W + 2;
    localparam int VSQ_W  = 2 * V_W;
    localparam int VV_W   = VSQ_W + 2;
    localparam int T_W    = C + 3;
    localparam int TR_W   = DOT_W + 1 - DIR_FRAC_BITS;
    localparam int TT_W   = 2 * T_W;
    localparam int RR_W   = 2 * (C - 1);
    localparam int S_W    = TT_W + 1;
    localparam int DF_W   = S_W + 1;
    localparam int RAD_W  = 2 * C + 7;
    localparam int G_W    = 3 * C + 3 * DIR_W;
    localparam int NST    = 7;
    localparam int HALF   = 1 << (DIR_FRAC_BITS - 1);

    logic [NST-1:0] r_vld;
    logic           w_en;

    assign w_en    = !r_vld[NST-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // origin and direction ride along, one copy per stage
    logic [G_W-1:0] r_geo [NST-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_geo[0] <= {i_dir_z, i_dir_y, i_dir_x, i_org_z, i_org_y, i_org_x};
            for (int k = 1; k < NST - 1; k++) begin
                r_geo[k] <= r_geo[k-1];
            end
        end
    end

    // stage 1: v = center - origin
    logic signed [V_W-1:0] r1_vx, r1_vy, r1_vz;

    // stage 2: products
    logic signed [DP_W-1:0]  r2_pdx, r2_pdy, r2_pdz;
    logic signed [VSQ_W-1:0] r2_sqx, r2_sqy, r2_sqz;
    logic signed [DIR_W-1:0] w_dx, w_dy, w_dz;

    assign w_dx = $signed(r_geo[0][3*C +: DIR_W]);
    assign w_dy = $signed(r_geo[0][3*C+DIR_W +: DIR_W]);
    assign w_dz = $signed(r_geo[0][3*C+2*DIR_W +: DIR_W]);

    // stage 3: sums and r^2
    logic signed [DOT_W-1:0] r3_dot;
    logic signed [VV_W-1:0]  r3_vv;
    logic        [RR_W-1:0]  r3_r2;

    // stage 4: rounded, clamped projection
    logic [DOT_W:0]         n4_rnd;
    logic [TR_W-1:0]        n4_traw;
    logic [T_W-1:0]         n4_t;
    logic                   r4_pos;
    logic [T_W-1:0]         r4_t;
    logic signed [VV_W-1:0] r4_vv;
    logic [RR_W-1:0]        r4_r2;

    assign n4_rnd  = {1'b0, r3_dot} + (DOT_W+1)'(HALF);
    assign n4_traw = n4_rnd[DOT_W:DIR_FRAC_BITS];
    assign n4_t    = (|n4_traw[TR_W-1:T_W]) ? {T_W{1'b1}} : n4_traw[T_W-1:0];

    // stage 5: t^2
    logic                   r5_pos;
    logic [T_W-1:0]         r5_t;
    logic [TT_W-1:0]        r5_tt;
    logic signed [VV_W-1:0] r5_vv;
    logic [RR_W-1:0]        r5_r2;

    // stage 6: r^2 + t^2
    logic                   r6_pos;
    logic [T_W-1:0]         r6_t;
    logic [S_W-1:0]         r6_s;
    logic signed [VV_W-1:0] r6_vv;

    // stage 7: radicand; a negative difference means the ray misses
    logic signed [DF_W-1:0] n7_diff;
    logic                   n7_hit;
    logic [RAD_W-1:0]       r7_rad;
    logic [4*C+3*DIR_W+3:0] r7_side;

    assign n7_diff = $signed({1'b0, r6_s}) - DF_W'(r6_vv);
    assign n7_hit  = r6_pos && !n7_diff[DF_W-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_vx   <= V_W'(i_cen_x) - V_W'(i_org_x);
            r1_vy   <= V_W'(i_cen_y) - V_W'(i_org_y);
            r1_vz   <= V_W'(i_cen_z) - V_W'(i_org_z);

            r2_pdx  <= DP_W'(r1_vx) * DP_W'(w_dx);
            r2_pdy  <= DP_W'(r1_vy) * DP_W'(w_dy);
            r2_pdz  <= DP_W'(r1_vz) * DP_W'(w_dz);
            r2_sqx  <= VSQ_W'(r1_vx) * VSQ_W'(r1_vx);
            r2_sqy  <= VSQ_W'(r1_vy) * VSQ_W'(r1_vy);
            r2_sqz  <= VSQ_W'(r1_vz) * VSQ_W'(r1_vz);

            r3_dot  <= DOT_W'(r2_pdx) + DOT_W'(r2_pdy) + DOT_W'(r2_pdz);
            r3_vv   <= VV_W'(r2_sqx) + VV_W'(r2_sqy) + VV_W'(r2_sqz);
            r3_r2   <= RR_W'(i_radius) * RR_W'(i_radius);

            r4_pos  <= !r3_dot[DOT_W-1];
            r4_t    <= n4_t;
            r4_vv   <= r3_vv;
            r4_r2   <= r3_r2;

            r5_pos  <= r4_pos;
            r5_t    <= r4_t;
            r5_tt   <= TT_W'(r4_t) * TT_W'(r4_t);
            r5_vv   <= r4_vv;
            r5_r2   <= r4_r2;

            r6_pos  <= r5_pos;
            r6_t    <= r5_t;
            r6_s    <= S_W'(r5_tt) + S_W'(r5_r2);
            r6_vv   <= r5_vv;

            r7_rad  <= n7_diff[RAD_W-1:0];
            r7_side <= {n7_hit, r6_t, r_geo[NST-2]};
        end
    end

    assign o_radicand = r7_rad;
    assign o_side     = r7_side;

endmodule

/* hdl/rsec_sqrt.sv */
// ----------------------------------------------------------------------------
// rsec_sqrt
// Pipelined integer square root, one result bit per stage, with a side
// payload carried alongside. Gives floor(sqrt(radicand)).
// ----------------------------------------------------------------------------
module rsec_sqrt #(
    parameter int RAD_W  = 55,
    parameter int SIDE_W = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [RAD_W-1:0]           i_radicand,
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [(RAD_W+1)/2-1:0]     o_root,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int Q_W = (RAD_W + 1) / 2;
    localparam int P_W = 2 * Q_W;
    localparam int R_W = Q_W + 2;

    logic [Q_W-1:0] r_vld;
    logic           w_en;

    assign w_en    = !r_vld[Q_W-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[Q_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Q_W-2:0], i_valid};
        end
    end

    logic [P_W-1:0]    r_rad  [Q_W-1];
    logic [R_W-1:0]    r_rem  [Q_W-1];
    logic [Q_W-1:0]    r_root [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [P_W-1:0]    w_rad;
        logic [R_W-1:0]    w_rem;
        logic [Q_W-1:0]    w_root;
        logic [SIDE_W-1:0] w_side;
        logic [R_W-1:0]    w_sh;
        logic [R_W-1:0]    w_trial;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_rad  = P_W'(i_radicand);
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_rad  = r_rad[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_side = r_side[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign w_sh    = {w_rem[R_W-3:0], w_rad[P_W-1 -: 2]};
        assign w_trial = {w_root, 2'b01};
        assign w_ge    = w_sh >= w_trial;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_root[k] <= {w_root[Q_W-2:0], w_ge};
                r_side[k] <= w_side;
            end
        end

        if (k < Q_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_rem[k] <= w_ge ? (w_sh - w_trial) : w_sh;
                    r_rad[k] <= {w_rad[P_W-3:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[Q_W-1];
    assign o_side = r_side[Q_W-1];

endmodule

/* hdl/rsec_exit.sv */
// ----------------------------------------------------------------------------
// rsec_exit
// Back end: path length t + root, scaling of the direction, rounding and
// saturation of the exit point. The last stage is the output register.
// ----------------------------------------------------------------------------
module rsec_exit #(
    parameter int COORD_BITS    = 24,
    parameter int DIR_FRAC_BITS = 14
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  logic [COORD_BITS+3:0]                       i_root,
    // side: origin x,y,z, dir x,y,z, t, hit (lowest bit up)
    input  logic [4*COORD_BITS+3*rsec_pkg::DIR_W+3:0]   i_side,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output logic                                        o_hit,
    output logic signed [COORD_BITS-1:0]                o_exit_x,
    output logic signed [COORD_BITS-1:0]                o_exit_y,
    output logic signed [COORD_BITS-1:0]                o_exit_z
);
    import rsec_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int T_W    = C + 3;
    localparam int L_W    = C + 5;
    localparam int M_W    = L_W + 1 + DIR_W;
    localparam int P_W    = M_W + 1;
    localparam int ST_W   = P_W - DIR_FRAC_BITS;
    localparam int E_W    = ST_W + 1;
    localparam int G_W    = 3 * C + 3 * DIR_W;
    localparam int SIDE_W = 4 * C + 3 * DIR_W + 4;
    localparam int NST    = 4;
    localparam int HALF   = 1 << (DIR_FRAC_BITS - 1);

    function automatic logic [C-1:0] sat_coord(input logic signed [E_W-1:0] e);
        logic [E_W-C:0] top;
        top = e[E_W-1:C-1];
        if ((&top) || !(|top)) begin
            return e[C-1:0];
        end else if (e[E_W-1]) begin
            return {1'b1, {(C-1){1'b0}}};
        end else begin
            return {1'b0, {(C-1){1'b1}}};
        end
    endfunction

    logic [NST-1:0] r_vld;
    logic           w_en;

    assign w_en    = !r_vld[NST-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    logic [T_W-1:0] w_t;
    assign w_t = i_side[G_W +: T_W];

    // stage 1: length along the ray
    logic [L_W-1:0] r1_len;
    logic           r1_hit;
    logic [G_W-1:0] r1_geo;

    // stage 2: length * direction
    logic signed [M_W-1:0]   r2_px, r2_py, r2_pz;
    logic                    r2_hit;
    logic [3*C-1:0]          r2_org;
    logic signed [DIR_W-1:0] w_dx, w_dy, w_dz;

    assign w_dx = $signed(r1_geo[3*C +: DIR_W]);
    assign w_dy = $signed(r1_geo[3*C+DIR_W +: DIR_W]);
    assign w_dz = $signed(r1_geo[3*C+2*DIR_W +: DIR_W]);

    // stage 3: round half up, floor back to coordinate units
    logic signed [P_W-1:0]  n3_rx, n3_ry, n3_rz;
    logic signed [ST_W-1:0] r3_sx, r3_sy, r3_sz;
    logic                   r3_hit;
    logic [3*C-1:0]         r3_org;

    assign n3_rx = P_W'(r2_px) + P_W'(HALF);
    assign n3_ry = P_W'(r2_py) + P_W'(HALF);
    assign n3_rz = P_W'(r2_pz) + P_W'(HALF);

    // stage 4: origin + step, saturate; output register
    logic signed [E_W-1:0] n4_ex, n4_ey, n4_ez;
    logic                  r4_hit;
    logic [C-1:0]          r4_ex, r4_ey, r4_ez;

    assign n4_ex = E_W'($signed(r3_org[0 +: C]))   + E_W'(r3_sx);
    assign n4_ey = E_W'($signed(r3_org[C +: C]))   + E_W'(r3_sy);
    assign n4_ez = E_W'($signed(r3_org[2*C +: C])) + E_W'(r3_sz);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_len <= L_W'(w_t) + L_W'(i_root);
            r1_hit <= i_side[SIDE_W-1];
            r1_geo <= i_side[G_W-1:0];

            r2_px  <= M_W'($signed({1'b0, r1_len})) * M_W'(w_dx);
            r2_py  <= M_W'($signed({1'b0, r1_len})) * M_W'(w_dy);
            r2_pz  <= M_W'($signed({1'b0, r1_len})) * M_W'(w_dz);
            r2_hit <= r1_hit;
            r2_org <= r1_geo[3*C-1:0];

            r3_sx  <= $signed(n3_rx[P_W-1:DIR_FRAC_BITS]);
            r3_sy  <= $signed(n3_ry[P_W-1:DIR_FRAC_BITS]);
            r3_sz  <= $signed(n3_rz[P_W-1:DIR_FRAC_BITS]);
            r3_hit <= r2_hit;
            r3_org <= r2_org;

            r4_hit <= r3_hit;
            r4_ex  <= r3_hit ? sat_coord(n4_ex) : '0;
            r4_ey  <= r3_hit ? sat_coord(n4_ey) : '0;
            r4_ez  <= r3_hit ? sat_coord(n4_ez) : '0;
        end
    end

    assign o_hit    = r4_hit;
    assign o_exit_x = $signed(r4_ex);
    assign o_exit_y = $signed(r4_ey);
    assign o_exit_z = $signed(r4_ez);

endmodule
